// ===== rtl/jsu_pkg.sv =====
package jsu_pkg;

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_BODY   = 2'd1;
    localparam logic [1:0] PH_ESCAPE = 2'd2;
    localparam logic [1:0] PH_UNI    = 2'd3;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [2:0] ERR_NOT_STRING  = 3'd0;
    localparam logic [2:0] ERR_UNCLOSED    = 3'd1;
    localparam logic [2:0] ERR_ESCAPE_CUT  = 3'd2;
    localparam logic [2:0] ERR_UNICODE_CUT = 3'd3;
    localparam logic [2:0] ERR_BAD_HEX     = 3'd4;
    localparam logic [2:0] ERR_UNKNOWN_ESC = 3'd5;

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_BS        = 8'h08;
    localparam logic [7:0] CH_FF        = 8'h0C;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_B         = 8'h62;
    localparam logic [7:0] CH_F         = 8'h66;
    localparam logic [7:0] CH_U         = 8'h75;

    localparam logic [15:0] CP_ONE_LIMIT = 16'h0080;
    localparam logic [15:0] CP_TWO_LIMIT = 16'h0800;
    localparam logic [7:0]  UTF_LEAD2    = 8'hC0;
    localparam logic [7:0]  UTF_LEAD3    = 8'hE0;
    localparam logic [7:0]  UTF_CONT     = 8'h80;
    localparam logic [7:0]  UTF_CONT_MASK = 8'h3F;

    localparam int GROUP_MAX = 3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [2:0] err;
    } jsu_result_t;

    typedef struct packed {
        logic [1:0]                    count;
        jsu_result_t [GROUP_MAX-1:0]   res;
    } jsu_group_t;

    typedef struct packed {
        logic [1:0]  phase;
        logic [1:0]  digits;
        logic [15:0] code_point;
        logic        bad_hex;
    } jsu_state_t;

    function automatic jsu_result_t make_result(logic [1:0] kind, logic [7:0] data,
                                                logic [2:0] err);
        jsu_result_t r;
        r.kind = kind;
        r.data = data;
        r.err  = err;
        return r;
    endfunction

    function automatic logic [4:0] hex_value(logic [7:0] c);
        logic [4:0] v;
        v = 5'd16;
        if (c >= 8'h30 && c <= 8'h39) v = 5'(c - 8'h30);
        else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h57);
        else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h37);
        return v;
    endfunction

endpackage

// ===== rtl/json_string_unescape.sv =====
// An accepted beat is held in the input register and decoded combinationally there; its
// results are loaded into the output buffer once it can take them and offered on the m_ side.
// Throughput: one input beat per cycle while each beat yields at most one result and
// m_ready is high. A \u escape yielding two or three UTF-8 bytes occupies the result port,
// holding the next result-producing beat until the escape's last byte is being taken.
// Reset (aresetn low, synchronous): decoder returns to idle, all buffers empty.
module json_string_unescape
    import jsu_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_end_of_text,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_kind,
    output logic [7:0] m_out_byte,
    output logic [2:0] m_error_code,
    output logic       m_last_of_run
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_eot_reg;
    jsu_state_t state_reg, state_next;
    jsu_group_t grp;
    logic       can_load;
    logic       fire;
    logic       load;

    assign fire    = in_valid_reg && (grp.count == 2'd0 || can_load);
    assign load    = fire && (grp.count != 2'd0);
    assign s_ready = !in_valid_reg || fire;

    jsu_decode u_decode (
        .st      (state_reg),
        .in_byte (in_byte_reg),
        .eot     (in_eot_reg),
        .nxt     (state_next),
        .grp     (grp)
    );

    jsu_outbuf u_outbuf (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (load),
        .grp           (grp),
        .can_load      (can_load),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_out_byte    (m_out_byte),
        .m_error_code  (m_error_code),
        .m_last_of_run (m_last_of_run)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            state_reg    <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (fire) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_in_byte;
            in_eot_reg  <= s_end_of_text;
        end
    end

`ifndef SYNTH
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("input register empty but not ready");

    a_multi_from_unicode: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && grp.count > 2'd1) |-> (state_reg.phase == PH_UNI))
        else $error("multi-byte group outside unicode escape");

    a_error_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && grp.count != 2'd0 && grp.res[0].kind == KIND_ERROR)
        |=> (state_reg.phase == PH_IDLE))
        else $error("error did not return decoder to idle");

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> m_valid)
        else $error("loaded group not offered");
`endif

endmodule

// ===== rtl/jsu_decode.sv =====
module jsu_decode
    import jsu_pkg::*;
(
    input  jsu_state_t st,
    input  logic [7:0] in_byte,
    input  logic       eot,
    output jsu_state_t nxt,
    output jsu_group_t grp
);

    logic [4:0]  hv;
    logic        is_hex;
    logic [15:0] cp_new;

    assign hv     = hex_value(in_byte);
    assign is_hex = !hv[4];
    assign cp_new = {st.code_point[11:0], is_hex ? hv[3:0] : 4'h0};

    always_comb begin
        nxt = st;
        grp = '0;
        unique case (st.phase)
            PH_IDLE: begin
                if (eot) begin
                    grp.count  = 2'd1;
                    grp.res[0] = make_result(KIND_ERROR, 8'h00, ERR_NOT_STRING);
                end else if (in_byte == CH_SPACE || in_byte == CH_TAB ||
                             in_byte == CH_CR || in_byte == CH_LF) begin
                    grp.count = 2'd0;
                end else if (in_byte == CH_QUOTE) begin
                    nxt.phase = PH_BODY;
                end else begin
                    grp.count  = 2'd1;
                    grp.res[0] = make_result(KIND_ERROR, 8'h00, ERR_NOT_STRING);
                end
            end
            PH_BODY: begin
                if (eot) begin
                    nxt.phase  = PH_IDLE;
                    grp.count  = 2'd1;
                    grp.res[0] = make_result(KIND_ERROR, 8'h00, ERR_UNCLOSED);
                end else if (in_byte == CH_QUOTE) begin
                    nxt.phase  = PH_IDLE;
                    grp.count  = 2'd1;
                    grp.res[0] = make_result(KIND_CLOSE, 8'h00, 3'd0);
                end else if (in_byte == CH_BACKSLASH) begin
                    nxt.phase = PH_ESCAPE;
                end else begin
                    grp.count  = 2'd1;
                    grp.res[0] = make_result(KIND_DATA, in_byte, 3'd0);
                end
            end
            PH_ESCAPE: begin
                if (eot) begin
                    nxt.phase  = PH_IDLE;
                    grp.count  = 2'd1;
                    grp.res[0] = make_result(KIND_ERROR, 8'h00, ERR_ESCAPE_CUT);
                end else begin
                    nxt.phase = PH_BODY;
                    grp.count = 2'd1;
                    case (in_byte)
                        CH_QUOTE:     grp.res[0] = make_result(KIND_DATA, CH_QUOTE, 3'd0);
                        CH_BACKSLASH: grp.res[0] = make_result(KIND_DATA, CH_BACKSLASH, 3'd0);
                        CH_SLASH:     grp.res[0] = make_result(KIND_DATA, CH_SLASH, 3'd0);
                        CH_N:         grp.res[0] = make_result(KIND_DATA, CH_LF, 3'd0);
                        CH_R:         grp.res[0] = make_result(KIND_DATA, CH_CR, 3'd0);
                        CH_T:         grp.res[0] = make_result(KIND_DATA, CH_TAB, 3'd0);
                        CH_B:         grp.res[0] = make_result(KIND_DATA, CH_BS, 3'd0);
                        CH_F:         grp.res[0] = make_result(KIND_DATA, CH_FF, 3'd0);
                        CH_U: begin
                            nxt.phase      = PH_UNI;
                            nxt.digits     = 2'd0;
                            nxt.code_point = 16'h0000;
                            nxt.bad_hex    = 1'b0;
                            grp.count      = 2'd0;
                        end
                        default: begin
                            nxt.phase  = PH_IDLE;
                            grp.res[0] = make_result(KIND_ERROR, 8'h00, ERR_UNKNOWN_ESC);
                        end
                    endcase
                end
            end
            default: begin
                if (eot) begin
                    nxt.phase  = PH_IDLE;
                    grp.count  = 2'd1;
                    grp.res[0] = make_result(KIND_ERROR, 8'h00, ERR_UNICODE_CUT);
                end else if (st.digits != 2'd3) begin
                    nxt.code_point = cp_new;
                    nxt.digits     = st.digits + 2'd1;
                    nxt.bad_hex    = st.bad_hex | !is_hex;
                end else begin
                    nxt.code_point = cp_new;
                    nxt.digits     = 2'd0;
                    if (st.bad_hex || !is_hex) begin
                        nxt.bad_hex = 1'b0;
                        nxt.phase   = PH_IDLE;
                        grp.count   = 2'd1;
                        grp.res[0]  = make_result(KIND_ERROR, 8'h00, ERR_BAD_HEX);
                    end else begin
                        nxt.phase = PH_BODY;
                        if (cp_new < CP_ONE_LIMIT) begin
                            grp.count  = 2'd1;
                            grp.res[0] = make_result(KIND_DATA, cp_new[7:0], 3'd0);
                        end else if (cp_new < CP_TWO_LIMIT) begin
                            grp.count  = 2'd2;
                            grp.res[0] = make_result(KIND_DATA,
                                UTF_LEAD2 | {3'b000, cp_new[10:6]}, 3'd0);
                            grp.res[1] = make_result(KIND_DATA,
                                UTF_CONT | (cp_new[7:0] & UTF_CONT_MASK), 3'd0);
                        end else begin
                            grp.count  = 2'd3;
                            grp.res[0] = make_result(KIND_DATA,
                                UTF_LEAD3 | {4'h0, cp_new[15:12]}, 3'd0);
                            grp.res[1] = make_result(KIND_DATA,
                                UTF_CONT | (cp_new[13:6] & UTF_CONT_MASK), 3'd0);
                            grp.res[2] = make_result(KIND_DATA,
                                UTF_CONT | (cp_new[7:0] & UTF_CONT_MASK), 3'd0);
                        end
                    end
                end
            end
        endcase
    end

endmodule

// ===== rtl/jsu_outbuf.sv =====
module jsu_outbuf
    import jsu_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       load,
    input  jsu_group_t grp,
    output logic       can_load,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_kind,
    output logic [7:0] m_out_byte,
    output logic [2:0] m_error_code,
    output logic       m_last_of_run
);

    logic [1:0]  cnt_reg, cnt_next;
    logic [1:0]  ptr_reg, ptr_next;
    jsu_result_t res_reg [GROUP_MAX];
    jsu_result_t head;
    logic        pop;

    assign m_valid  = (cnt_reg != 2'd0);
    assign pop      = m_valid && m_ready;
    assign can_load = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_ready);
    assign head     = res_reg[ptr_reg];

    assign m_kind        = head.kind;
    assign m_out_byte    = head.data;
    assign m_error_code  = head.err;
    assign m_last_of_run = (cnt_reg == 2'd1);

    always_comb begin
        cnt_next = cnt_reg;
        ptr_next = ptr_reg;
        if (load) begin
            cnt_next = grp.count;
            ptr_next = 2'd0;
        end else if (pop) begin
            cnt_next = cnt_reg - 2'd1;
            ptr_next = ptr_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            ptr_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
            ptr_reg <= ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            for (int i = 0; i < GROUP_MAX; i++) begin
                res_reg[i] <= grp.res[i];
            end
        end
    end

endmodule

// ===== test/testbench.sv =====
module testbench;
    import jsu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [7:0] ch;
        logic       eot;
    } text_beat_t;

    typedef struct {
        logic [1:0] kind;
        logic [7:0] data;
        logic [2:0] err;
        logic       last;
    } reply_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte = 8'h00;
    logic       s_end_of_text = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [1:0] m_kind;
    logic [7:0] m_out_byte;
    logic [2:0] m_error_code;
    logic       m_last_of_run;

    text_beat_t text_q[$];
    text_beat_t next_beat;
    reply_t     expected_replies[$];
    reply_t     reply_group[$];
    reply_t     want;

    logic [1:0]  text_phase = PH_IDLE;
    logic [1:0]  digit_count = 2'd0;
    logic [15:0] cp_acc = 16'h0000;
    logic        saw_bad_digit = 1'b0;

    int  planned_items = 0;
    int  total_items = 1 << 30;
    int  beats_in = 0;
    int  beats_out = 0;
    int  replies_due = 0;
    int  closes_seen = 0;
    int  errors_seen = 0;
    int  failures = 0;
    int  tx_gap = 0;
    int  rx_gap = 0;
    logic hold_rx = 1'b0;
    logic idling;

    logic [7:0] simple_escapes [8] = '{CH_QUOTE, CH_BACKSLASH, CH_SLASH, CH_N,
                                       CH_R, CH_T, CH_B, CH_F};

    assign idling = (beats_in + 40 < total_items);

    json_string_unescape uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_byte     (s_in_byte),
        .s_end_of_text (s_end_of_text),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_out_byte    (m_out_byte),
        .m_error_code  (m_error_code),
        .m_last_of_run (m_last_of_run)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic logic [4:0] nibble_of(logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return {1'b0, c[3:0]};
        if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
            return 5'(c[3:0] + 4'd9);
        return 5'd16;
    endfunction

    function automatic void emit(logic [1:0] kind, logic [7:0] data, logic [2:0] err);
        reply_t r;
        r.kind = kind;
        r.data = data;
        r.err  = err;
        r.last = 1'b0;
        reply_group = {reply_group, r};
    endfunction

    function automatic void abort_text(logic [2:0] err);
        text_phase = PH_IDLE;
        emit(KIND_ERROR, 8'h00, err);
    endfunction

    function automatic void decode_beat(logic [7:0] c, logic eot);
        logic [4:0] nib;
        reply_t     r;
        reply_group.delete();
        case (text_phase)
            PH_IDLE: begin
                if (eot) abort_text(ERR_NOT_STRING);
                else if (c == CH_QUOTE) text_phase = PH_BODY;
                else if (!(c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF))
                    abort_text(ERR_NOT_STRING);
            end
            PH_BODY: begin
                if (eot) begin
                    abort_text(ERR_UNCLOSED);
                end else if (c == CH_QUOTE) begin
                    text_phase = PH_IDLE;
                    emit(KIND_CLOSE, 8'h00, 3'd0);
                end else if (c == CH_BACKSLASH) begin
                    text_phase = PH_ESCAPE;
                end else begin
                    emit(KIND_DATA, c, 3'd0);
                end
            end
            PH_ESCAPE: begin
                if (eot) begin
                    abort_text(ERR_ESCAPE_CUT);
                end else if (c == CH_U) begin
                    text_phase = PH_UNI;
                    digit_count = 2'd0;
                    cp_acc = 16'h0000;
                    saw_bad_digit = 1'b0;
                end else begin
                    text_phase = PH_BODY;
                    case (c)
                        CH_QUOTE, CH_BACKSLASH, CH_SLASH: emit(KIND_DATA, c, 3'd0);
                        CH_N: emit(KIND_DATA, CH_LF, 3'd0);
                        CH_R: emit(KIND_DATA, CH_CR, 3'd0);
                        CH_T: emit(KIND_DATA, CH_TAB, 3'd0);
                        CH_B: emit(KIND_DATA, CH_BS, 3'd0);
                        CH_F: emit(KIND_DATA, CH_FF, 3'd0);
                        default: abort_text(ERR_UNKNOWN_ESC);
                    endcase
                end
            end
            default: begin
                if (eot) begin
                    abort_text(ERR_UNICODE_CUT);
                end else begin
                    nib = nibble_of(c);
                    if (nib[4]) begin
                        saw_bad_digit = 1'b1;
                        nib = 5'd0;
                    end
                    cp_acc = {cp_acc[11:0], nib[3:0]};
                    if (digit_count != 2'd3) begin
                        digit_count = digit_count + 2'd1;
                    end else begin
                        digit_count = 2'd0;
                        if (saw_bad_digit) begin
                            saw_bad_digit = 1'b0;
                            abort_text(ERR_BAD_HEX);
                        end else begin
                            text_phase = PH_BODY;
                            if (cp_acc < CP_ONE_LIMIT) begin
                                emit(KIND_DATA, cp_acc[7:0], 3'd0);
                            end else if (cp_acc < CP_TWO_LIMIT) begin
                                emit(KIND_DATA, UTF_LEAD2 | 8'(cp_acc >> 6), 3'd0);
                                emit(KIND_DATA, UTF_CONT | (cp_acc[7:0] & UTF_CONT_MASK), 3'd0);
                            end else begin
                                emit(KIND_DATA, UTF_LEAD3 | 8'(cp_acc >> 12), 3'd0);
                                emit(KIND_DATA, UTF_CONT | (8'(cp_acc >> 6) & UTF_CONT_MASK),
                                     3'd0);
                                emit(KIND_DATA, UTF_CONT | (cp_acc[7:0] & UTF_CONT_MASK), 3'd0);
                            end
                        end
                    end
                end
            end
        endcase
        if (reply_group.size() != 0) reply_group[reply_group.size() - 1].last = 1'b1;
        foreach (reply_group[i]) begin
            r = reply_group[i];
            expected_replies = {expected_replies, r};
            replies_due++;
        end
    endfunction

    task automatic flag(string what);
        $display("MISMATCH at result beat %0d: %s", beats_out, what);
        failures++;
    endtask

    task automatic put_byte(logic [7:0] b);
        text_beat_t t;
        t.ch  = b;
        t.eot = 1'b0;
        text_q = {text_q, t};
        planned_items++;
    endtask

    task automatic put_end();
        text_beat_t t;
        t.ch  = 8'($urandom_range(0, 255));
        t.eot = 1'b1;
        text_q = {text_q, t};
        planned_items++;
    endtask

    task automatic put_pad();
        text_beat_t t;
        logic [7:0] pads [4];
        pads = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};
        t.ch  = pads[$urandom_range(0, 3)];
        t.eot = 1'b0;
        text_q = {text_q, t};
        planned_items++;
    endtask

    function automatic logic [7:0] hex_char(logic [3:0] n);
        if (n < 4'd10) return 8'h30 + 8'(n);
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
    endfunction

    function automatic logic [7:0] non_hex_byte();
        logic [7:0] b;
        logic [4:0] nib;
        b = 8'($urandom_range(0, 255));
        nib = nibble_of(b);
        while (!nib[4]) begin
            b = 8'($urandom_range(0, 255));
            nib = nibble_of(b);
        end
        return b;
    endfunction

    function automatic logic [7:0] odd_escape();
        logic [7:0] b;
        logic       known;
        known = 1'b1;
        b = 8'h00;
        while (known) begin
            b = 8'($urandom_range(0, 255));
            known = (b == CH_U);
            foreach (simple_escapes[i]) if (b == simple_escapes[i]) known = 1'b1;
        end
        return b;
    endfunction

    task automatic put_unicode();
        logic [15:0] cp;
        case ($urandom_range(0, 9))
            0: cp = 16'h0000;
            1: cp = 16'h007F;
            2: cp = 16'h0080;
            3: cp = 16'h07FF;
            4: cp = 16'h0800;
            5: cp = 16'hFFFF;
            6: cp = 16'hD800 + 16'($urandom_range(0, 16'h7FF));
            7: cp = 16'($urandom_range(0, 16'h7F));
            8: cp = 16'($urandom_range(16'h80, 16'h7FF));
            default: cp = 16'($urandom_range(0, 16'hFFFF));
        endcase
        put_byte(CH_BACKSLASH);
        put_byte(CH_U);
        for (int i = 3; i >= 0; i--) put_byte(hex_char(cp[i*4 +: 4]));
    endtask

    task automatic put_element();
        int pick;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            b = 8'($urandom_range(0, 255));
            while (b == CH_QUOTE || b == CH_BACKSLASH) b = 8'($urandom_range(0, 255));
            put_byte(b);
        end else if (pick < 75) begin
            put_byte(CH_BACKSLASH);
            put_byte(simple_escapes[$urandom_range(0, 7)]);
        end else begin
            put_unicode();
        end
    endtask

    task automatic random_text();
        int pick;
        int bad_at;
        logic [7:0] b;
        repeat ($urandom_range(0, 2)) put_pad();
        if ($urandom_range(0, 99) < 12) begin
            if ($urandom_range(0, 1)) begin
                put_end();
            end else begin
                b = 8'($urandom_range(0, 255));
                while (b == CH_QUOTE || b == CH_SPACE || b == CH_TAB || b == CH_CR ||
                       b == CH_LF)
                    b = 8'($urandom_range(0, 255));
                put_byte(b);
            end
        end else begin
            put_byte(CH_QUOTE);
            repeat ($urandom_range(0, 6)) put_element();
            pick = $urandom_range(0, 99);
            if (pick < 78) begin
                put_byte(CH_QUOTE);
            end else if (pick < 83) begin
                put_end();
            end else if (pick < 87) begin
                put_byte(CH_BACKSLASH);
                put_end();
            end else if (pick < 91) begin
                put_byte(CH_BACKSLASH);
                put_byte(odd_escape());
            end else if (pick < 95) begin
                put_byte(CH_BACKSLASH);
                put_byte(CH_U);
                repeat ($urandom_range(0, 3))
                    put_byte($urandom_range(0, 1) ? hex_char(4'($urandom_range(0, 15)))
                                                  : 8'($urandom_range(0, 255)));
                put_end();
            end else begin
                put_byte(CH_BACKSLASH);
                put_byte(CH_U);
                bad_at = $urandom_range(0, 3);
                for (int i = 0; i < 4; i++)
                    put_byte(i == bad_at ? non_hex_byte() : hex_char(4'($urandom_range(0, 15))));
            end
        end
    endtask

    initial begin
        put_end();
        put_pad();
        put_pad();
        put_pad();
        put_pad();
        put_byte(8'hFF);
        put_byte(CH_QUOTE);
        put_byte(8'h00);
        put_end();
        put_byte(CH_QUOTE);
        put_byte(CH_BACKSLASH);
        put_end();
        put_byte(CH_QUOTE);
        put_byte(CH_BACKSLASH);
        put_byte(8'h71);
        put_byte(CH_QUOTE);
        put_byte(CH_BACKSLASH);
        put_byte(CH_U);
        put_byte(8'h67);
        put_end();
        put_byte(CH_QUOTE);
        put_byte(CH_BACKSLASH);
        put_byte(CH_U);
        put_byte(CH_QUOTE);
        put_byte(CH_BACKSLASH);
        put_byte(8'h30);
        put_byte(8'h30);
        put_byte(CH_QUOTE);
        put_byte(CH_QUOTE);
        while (planned_items < 172) random_text();
        total_items = text_q.size();

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        wait (beats_in == total_items);
        wait (replies_due == 0);
        repeat (12) @(posedge aclk);

        $display("Sent %0d text beats, checked %0d result beats (%0d closes, %0d errors).",
                 beats_in, beats_out, closes_seen, errors_seen);
        $display("Covered escapes, unicode widths, surrogates, all error kinds, stalls.");
        if (failures == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        wait (beats_in >= 60);
        @(posedge aclk);
        hold_rx <= 1'b1;
        repeat (200) @(posedge aclk);
        hold_rx <= 1'b0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                decode_beat(s_in_byte, s_end_of_text);
                beats_in <= beats_in + 1;
            end
            if (!s_valid || s_ready) begin
                if (tx_gap > 0) begin
                    tx_gap  <= tx_gap - 1;
                    s_valid <= 1'b0;
                end else if (text_q.size() != 0 && idling && $urandom_range(0, 9) == 0) begin
                    tx_gap  <= $urandom_range(0, 13);
                    s_valid <= 1'b0;
                end else if (text_q.size() != 0) begin
                    next_beat = text_q.pop_front();
                    s_in_byte     <= next_beat.ch;
                    s_end_of_text <= next_beat.eot;
                    s_valid       <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid === 1'b1 && m_ready) begin
                beats_out <= beats_out + 1;
                if (replies_due == 0) begin
                    flag("result beat with nothing expected");
                end else begin
                    want = expected_replies.pop_front();
                    replies_due--;
                    if (want.kind == KIND_CLOSE) closes_seen++;
                    if (want.kind == KIND_ERROR) errors_seen++;
                    if (m_kind !== want.kind)
                        flag($sformatf("kind got %0d want %0d", m_kind, want.kind));
                    if (m_out_byte !== want.data)
                        flag($sformatf("out_byte got %02h want %02h", m_out_byte, want.data));
                    if (m_error_code !== want.err)
                        flag($sformatf("error_code got %0d want %0d", m_error_code, want.err));
                    if (m_last_of_run !== want.last)
                        flag($sformatf("last_of_run got %0d want %0d", m_last_of_run,
                                       want.last));
                end
            end
            if (hold_rx) begin
                m_ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap  <= rx_gap - 1;
                m_ready <= 1'b0;
            end else if (idling && $urandom_range(0, 7) == 0) begin
                rx_gap  <= $urandom_range(0, 13);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

endmodule

// ===== sim.f =====
rtl/jsu_pkg.sv
rtl/jsu_decode.sv
rtl/jsu_outbuf.sv
rtl/json_string_unescape.sv
test/testbench.sv
